FILE: rtl/slrf_pkg.sv
package slrf_pkg;

  localparam int unsigned NUM_WRITES = 25;
  localparam int unsigned CNT_W      = $clog2(NUM_WRITES);
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned NUM_W      = 14;
  localparam int unsigned TIME_W     = 19;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(2 * (NUM_WRITES - 1));

  localparam logic [NUM_W-1:0]  NUM_MAX     = NUM_W'(9999);
  localparam logic [NUM_W-1:0]  BLANK_LIMIT = NUM_W'(999);
  localparam logic [NUM_W-1:0]  TENS_LIMIT  = NUM_W'(99);
  localparam logic [TIME_W-1:0] TIME_MAX    = TIME_W'(359999);
  localparam logic [TIME_W-1:0] HOUR_SECS   = TIME_W'(3600);

  localparam logic [7:0] SEG_DASH   = 8'h20;
  localparam logic [7:0] SEG_OFF    = 8'h00;
  localparam logic [7:0] LEGEND_P   = 8'h73;
  localparam logic [7:0] LEGEND_BAR = 8'h20;
  localparam logic [7:0] LEGEND_TWO = 8'h6B;

  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  typedef struct packed {
    logic [3:0] q1000;
    logic [6:0] q100;
    logic [9:0] q10;
  } quot_t;

  typedef struct packed {
    logic st_zero;
    logic st_b3;
    logic st_b2;
    logic at_b3;
    logic at_b2;
    logic hide;
    logic pre_zero;
    logic pre_hour;
  } flags_t;

  function automatic logic [7:0] act_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'hF5;
      4'd1: s = 8'h05;
      4'd2: s = 8'hD3;
      4'd3: s = 8'h97;
      4'd4: s = 8'h27;
      4'd5: s = 8'hB6;
      4'd6: s = 8'hF6;
      4'd7: s = 8'h15;
      4'd8: s = 8'hF7;
      4'd9: s = 8'hB7;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] set_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'h5F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h6B;
      4'd3: s = 8'h2F;
      4'd4: s = 8'h36;
      4'd5: s = 8'h3D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h3F;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] tim_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'h5F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h3D;
      4'd3: s = 8'h2F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6B;
      4'd6: s = 8'h7B;
      4'd7: s = 8'h0E;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/segment_lcd_readout_formatter_unit.sv
// Seven-segment LCD readout formatter. Each accepted item is one display
// snapshot; it passes a four-stage pipeline (input register, reciprocal
// quotients, digits, time digits) and is then sent as 25 LCD RAM writes to
// addresses 0, 2, ..., 48, one per cycle while out_ready_i is high, with
// last_write_o marking address 48. The output shift register therefore
// sets the rate: a new item is loaded only after the last write of the
// previous refresh. Up to four more items wait in the pipeline while a
// refresh drains; once all four are full, in_ready_o drops.
module segment_lcd_readout_formatter_unit
  import slrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NUM_W-1:0]    set_temp_i,
  input  logic [NUM_W-1:0]    actual_temp_i,
  input  logic [NUM_W-1:0]    set_speed_i,
  input  logic [NUM_W-1:0]    actual_speed_i,
  input  logic                hide_set_speed_i,
  input  logic [TIME_W-1:0]   time_preset_i,
  input  logic [TIME_W-1:0]   time_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ADDR_W-1:0]   lcd_address_o,
  output logic [7:0]          lcd_data_o,
  output logic                last_write_o
);

  function automatic quot_t quot_of(input logic [NUM_W-1:0] v);
    logic [29:0] p10;
    logic [26:0] p100;
    logic [27:0] p1000;
    quot_t       q;
    p10     = 30'(v) * 30'(52429);
    p100    = 27'(v) * 27'(5243);
    p1000   = 28'(v) * 28'(8389);
    q.q10   = p10[28:19];
    q.q100  = p100[25:19];
    q.q1000 = p1000[26:23];
    return q;
  endfunction

  function automatic digits_t digits_of(input logic [NUM_W-1:0] v, input quot_t q);
    logic [6:0]       r1;
    logic [9:0]       r2;
    logic [NUM_W-1:0] r3;
    digits_t          d;
    r1   = q.q100 - 7'(q.q1000) * 7'd10;
    r2   = q.q10 - 10'(q.q100) * 10'd10;
    r3   = v - NUM_W'(q.q10) * NUM_W'(10);
    d.d0 = q.q1000;
    d.d1 = r1[3:0];
    d.d2 = r2[3:0];
    d.d3 = r3[3:0];
    return d;
  endfunction

  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'(205);
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] x, input logic [3:0] t);
    logic [6:0] r;
    r = x - 7'(t) * 7'd10;
    return r[3:0];
  endfunction

  // stage 0: input register, saturated
  logic              s0_v_q;
  logic [NUM_W-1:0]  s0_st_q, s0_at_q, s0_sp_q, s0_ap_q;
  logic [TIME_W-1:0] s0_t_q;
  logic              s0_hide_q, s0_pzero_q, s0_phour_q;

  // stage 1: quotients
  logic              s1_v_q;
  logic [NUM_W-1:0]  s1_st_q, s1_at_q, s1_sp_q, s1_ap_q;
  quot_t             s1_qst_q, s1_qat_q, s1_qsp_q, s1_qap_q;
  logic [TIME_W-1:0] s1_t_q;
  logic [12:0]       s1_q60_q;
  logic [6:0]        s1_q3600_q;
  flags_t            s1_fl_q;

  // stage 2: digits
  logic              s2_v_q;
  digits_t           s2_dst_q, s2_dat_q, s2_dsp_q, s2_dap_q;
  logic [6:0]        s2_hi_q, s2_lo_q;
  flags_t            s2_fl_q;

  // stage 3: time digits
  logic              s3_v_q;
  digits_t           s3_dst_q, s3_dat_q, s3_dsp_q, s3_dap_q;
  digits_t           s3_dtm_q;
  flags_t            s3_fl_q;

  // output shift register
  logic              emit_v_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [7:0]        bytes_q [NUM_WRITES];

  logic rdy1, rdy2, rdy3, emit_free, in_acc, out_acc, is_last;

  assign is_last   = (cnt_q == CNT_W'(NUM_WRITES - 1));
  assign out_acc   = emit_v_q && out_ready_i;
  assign emit_free = !emit_v_q || (out_acc && is_last);
  assign rdy3      = !s3_v_q || emit_free;
  assign rdy2      = !s2_v_q || rdy3;
  assign rdy1      = !s1_v_q || rdy2;
  assign in_ready_o = !s0_v_q || rdy1;
  assign in_acc    = in_valid_i && in_ready_o;

  assign out_valid_o   = emit_v_q;
  assign lcd_address_o = {cnt_q, 1'b0};
  assign lcd_data_o    = bytes_q[0];
  assign last_write_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      emit_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        s0_v_q <= 1'b1;
      end else if (rdy1) begin
        s0_v_q <= 1'b0;
      end
      if (rdy1) begin
        s1_v_q <= s0_v_q;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy3) begin
        s3_v_q <= s2_v_q;
      end
      if (emit_free && s3_v_q) begin
        emit_v_q <= 1'b1;
        cnt_q    <= '0;
      end else if (out_acc) begin
        if (is_last) begin
          emit_v_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  function automatic logic [NUM_W-1:0] sat_num(input logic [NUM_W-1:0] v);
    return (v > NUM_MAX) ? NUM_MAX : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_st_q    <= sat_num(set_temp_i);
      s0_at_q    <= sat_num(actual_temp_i);
      s0_sp_q    <= sat_num(set_speed_i);
      s0_ap_q    <= sat_num(actual_speed_i);
      s0_t_q     <= (time_value_i > TIME_MAX) ? TIME_MAX : time_value_i;
      s0_hide_q  <= hide_set_speed_i;
      s0_pzero_q <= (time_preset_i == '0);
      s0_phour_q <= (time_preset_i >= HOUR_SECS);
    end
  end

  logic [37:0] p60;
  logic [38:0] p3600;
  assign p60   = 38'(s0_t_q) * 38'(279621);
  assign p3600 = 39'(s0_t_q) * 39'(596524);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_st_q          <= s0_st_q;
      s1_at_q          <= s0_at_q;
      s1_sp_q          <= s0_sp_q;
      s1_ap_q          <= s0_ap_q;
      s1_qst_q         <= quot_of(s0_st_q);
      s1_qat_q         <= quot_of(s0_at_q);
      s1_qsp_q         <= quot_of(s0_sp_q);
      s1_qap_q         <= quot_of(s0_ap_q);
      s1_t_q           <= s0_t_q;
      s1_q60_q         <= p60[36:24];
      s1_q3600_q       <= p3600[37:31];
      s1_fl_q.st_zero  <= (s0_st_q == '0);
      s1_fl_q.st_b3    <= (s0_st_q <= BLANK_LIMIT);
      s1_fl_q.st_b2    <= (s0_st_q <= TENS_LIMIT);
      s1_fl_q.at_b3    <= (s0_at_q <= BLANK_LIMIT);
      s1_fl_q.at_b2    <= (s0_at_q <= TENS_LIMIT);
      s1_fl_q.hide     <= s0_hide_q;
      s1_fl_q.pre_zero <= s0_pzero_q;
      s1_fl_q.pre_hour <= s0_phour_q;
    end
  end

  logic [TIME_W-1:0] sec_full;
  logic [12:0]       minh_full;
  logic [6:0]        sec_v, minh_v;
  assign sec_full  = s1_t_q - TIME_W'(s1_q60_q) * TIME_W'(60);
  assign minh_full = s1_q60_q - 13'(s1_q3600_q) * 13'd60;
  assign sec_v     = sec_full[6:0];
  assign minh_v    = minh_full[6:0];

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_dst_q <= digits_of(s1_st_q, s1_qst_q);
      s2_dat_q <= digits_of(s1_at_q, s1_qat_q);
      s2_dsp_q <= digits_of(s1_sp_q, s1_qsp_q);
      s2_dap_q <= digits_of(s1_ap_q, s1_qap_q);
      s2_hi_q  <= s1_fl_q.pre_hour ? s1_q3600_q : minh_v;
      s2_lo_q  <= s1_fl_q.pre_hour ? minh_v : sec_v;
      s2_fl_q  <= s1_fl_q;
    end
  end

  logic [3:0] hi_t, lo_t;
  assign hi_t = tens_of(s2_hi_q);
  assign lo_t = tens_of(s2_lo_q);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_dst_q    <= s2_dst_q;
      s3_dat_q    <= s2_dat_q;
      s3_dsp_q    <= s2_dsp_q;
      s3_dap_q    <= s2_dap_q;
      s3_dtm_q.d0 <= hi_t;
      s3_dtm_q.d1 <= ones_of(s2_hi_q, hi_t);
      s3_dtm_q.d2 <= lo_t;
      s3_dtm_q.d3 <= ones_of(s2_lo_q, lo_t);
      s3_fl_q     <= s2_fl_q;
    end
  end

  logic [7:0] ts [4];
  logic [7:0] ta [4];
  logic [7:0] ss [4];
  logic [7:0] sa [4];
  logic [7:0] tm [4];
  logic [7:0] pack [NUM_WRITES];

  always_comb begin
    ts[0] = set_seg(s3_dst_q.d0);
    ts[1] = set_seg(s3_dst_q.d1);
    ts[2] = set_seg(s3_dst_q.d2);
    ts[3] = set_seg(s3_dst_q.d3);
    if (s3_fl_q.st_b3) ts[0] = SEG_OFF;
    if (s3_fl_q.st_b2) ts[1] = SEG_OFF;
    if (s3_fl_q.st_zero) begin
      for (int i = 0; i < 4; i++) ts[i] = SEG_DASH;
    end

    ta[0] = s3_fl_q.at_b3 ? SEG_OFF : act_seg(s3_dat_q.d0);
    ta[1] = s3_fl_q.at_b2 ? SEG_OFF : act_seg(s3_dat_q.d1);
    ta[2] = act_seg(s3_dat_q.d2);
    ta[3] = act_seg(s3_dat_q.d3);

    ss[0] = s3_fl_q.hide ? SEG_OFF : set_seg(s3_dsp_q.d0);
    ss[1] = s3_fl_q.hide ? SEG_OFF : set_seg(s3_dsp_q.d1);
    ss[2] = s3_fl_q.hide ? SEG_OFF : set_seg(s3_dsp_q.d2);
    ss[3] = s3_fl_q.hide ? SEG_OFF : set_seg(s3_dsp_q.d3);

    sa[0] = act_seg(s3_dap_q.d0);
    sa[1] = act_seg(s3_dap_q.d1);
    sa[2] = act_seg(s3_dap_q.d2);
    sa[3] = act_seg(s3_dap_q.d3);

    tm[0] = s3_fl_q.pre_zero ? SEG_DASH : tim_seg(s3_dtm_q.d0);
    tm[1] = s3_fl_q.pre_zero ? SEG_DASH : tim_seg(s3_dtm_q.d1);
    tm[2] = s3_fl_q.pre_zero ? SEG_DASH : tim_seg(s3_dtm_q.d2);
    tm[3] = s3_fl_q.pre_zero ? SEG_DASH : tim_seg(s3_dtm_q.d3);

    // temperature
    pack[0]  = {1'b0, ts[0][6:4], ta[0][7:4]};
    pack[1]  = {1'b0, ts[0][3:0], ta[0][2:0]};
    pack[2]  = {1'b0, ts[1][6:4], ta[1][7:4]};
    pack[3]  = {1'b0, ts[1][3:0], ta[1][2:0]};
    pack[4]  = {1'b0, ts[2][6:4], ta[2][7:4]};
    pack[5]  = {ts[2][3:0], 1'b1, ta[2][2:0]};
    pack[6]  = {1'b1, ts[3][6:4], ta[3][7:4]};
    pack[7]  = {1'b1, ts[3][3:0], ta[3][2:0]};
    // speed
    pack[8]  = SEG_OFF;
    pack[9]  = {1'b0, ss[0][6:4], sa[0][7:4]};
    pack[10] = {1'b0, ss[0][3:0], sa[0][2:0]};
    pack[11] = {1'b0, ss[1][6:4], sa[1][7:4]};
    pack[12] = {ss[1][3:0], sa[1][2:0], 1'b0};
    pack[13] = {1'b0, ss[2][6:4], sa[2][7:4]};
    pack[14] = {1'b0, ss[2][3:0], sa[2][2:0]};
    pack[15] = {1'b0, ss[3][6:4], sa[3][7:4]};
    pack[16] = {1'b0, ss[3][3:0], sa[3][2:0]};
    // time and legend
    pack[17] = {4'b0, tm[0][3:0]};
    pack[18] = {5'b0, tm[0][6:4]};
    pack[19] = {LEGEND_P[6:4], 1'b0, tm[1][3:0]};
    pack[20] = {LEGEND_P[3:0], tm[1][6:4], 1'b0};
    pack[21] = {LEGEND_BAR[6:4], 1'b0, tm[2][3:0]};
    pack[22] = {LEGEND_BAR[3:0], 1'b0, tm[2][6:4]};
    pack[23] = {LEGEND_TWO[6:4], 1'b0, tm[3][3:0]};
    pack[24] = {LEGEND_TWO[3:0], 1'b0, tm[3][6:4]};
  end

  always_ff @(posedge clk_i) begin
    if (emit_free && s3_v_q) begin
      for (int k = 0; k < NUM_WRITES; k++) bytes_q[k] <= pack[k];
    end else if (out_acc) begin
      for (int k = 0; k < NUM_WRITES - 1; k++) bytes_q[k] <= bytes_q[k+1];
    end
  end

endmodule

FILE: rtl/slrf_checker.sv
module slrf_checker
  import slrf_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [NUM_W-1:0]    set_temp_i,
  input logic [NUM_W-1:0]    actual_temp_i,
  input logic [NUM_W-1:0]    set_speed_i,
  input logic [NUM_W-1:0]    actual_speed_i,
  input logic                hide_set_speed_i,
  input logic [TIME_W-1:0]   time_preset_i,
  input logic [TIME_W-1:0]   time_value_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [ADDR_W-1:0]   lcd_address_o,
  input logic [7:0]          lcd_data_o,
  input logic                last_write_o
);

  logic out_acc;
  assign out_acc = out_valid_o && out_ready_i;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(set_temp_i)
      && $stable(actual_temp_i) && $stable(set_speed_i) && $stable(actual_speed_i)
      && $stable(hide_set_speed_i) && $stable(time_preset_i) && $stable(time_value_i))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lcd_address_o)
      && $stable(lcd_data_o) && $stable(last_write_o))
    else $error("output item changed while stalled");

  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_write_o |=> out_valid_o
      && lcd_address_o == $past(lcd_address_o) + ADDR_W'(2))
    else $error("refresh writes not contiguous");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_write_o |=> !out_valid_o || lcd_address_o == '0)
    else $error("refresh does not start at address zero");

  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_write_o == (lcd_address_o == LAST_ADDR)) && !lcd_address_o[0])
    else $error("last flag and address disagree");

endmodule

bind segment_lcd_readout_formatter_unit slrf_checker u_slrf_checker (.*);

FILE: test/tb_top.sv
module tb_top;
  import slrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PRINT_CAP   = 40;

  // digit glyphs, digit 0 in the low byte
  localparam logic [79:0] ACT_SEGS = {8'hB7, 8'hF7, 8'h15, 8'hF6, 8'hB6,
                                      8'h27, 8'h97, 8'hD3, 8'h05, 8'hF5};
  localparam logic [79:0] SET_SEGS = {8'h3F, 8'h7F, 8'h07, 8'h7D, 8'h3D,
                                      8'h36, 8'h2F, 8'h6B, 8'h06, 8'h5F};
  localparam logic [79:0] TIM_SEGS = {8'h6F, 8'h7F, 8'h0E, 8'h7B, 8'h6B,
                                      8'h66, 8'h2F, 8'h3D, 8'h06, 8'h5F};

  typedef enum logic [1:0] {FONT_ACT, FONT_SET, FONT_TIM} font_e;

  typedef logic [0:3][7:0]  quad_t;
  typedef logic [0:24][7:0] frame_t;

  typedef struct packed {
    logic [NUM_W-1:0]  set_temp;
    logic [NUM_W-1:0]  actual_temp;
    logic [NUM_W-1:0]  set_speed;
    logic [NUM_W-1:0]  actual_speed;
    logic              hide;
    logic [TIME_W-1:0] preset;
    logic [TIME_W-1:0] tval;
  } snapshot_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              last;
  } lcd_write_t;

  typedef struct {
    snapshot_t snap;
    bit        golden;
    frame_t    gold;
  } vector_t;

  localparam frame_t NO_GOLD   = '0;
  localparam frame_t GOLD_ZERO =
    200'h20_00_20_00_2F_0D_AF_85_00_5F_7D_5F_FA_5F_7D_5F_7D_00_02_E0_34_40_02_C0_B2;
  localparam frame_t GOLD_MAX  =
    200'h3B_7F_3B_7F_3B_FF_BB_FF_00_3B_7F_3B_FE_3B_7F_3B_7F_0F_06_EF_3C_4B_06_CF_B6;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [NUM_W-1:0]  set_temp_i;
  logic [NUM_W-1:0]  actual_temp_i;
  logic [NUM_W-1:0]  set_speed_i;
  logic [NUM_W-1:0]  actual_speed_i;
  logic              hide_set_speed_i;
  logic [TIME_W-1:0] time_preset_i;
  logic [TIME_W-1:0] time_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ADDR_W-1:0] lcd_address_o;
  logic [7:0]        lcd_data_o;
  logic              last_write_o;

  lcd_write_t  pending_writes[$];
  vector_t     directed_rows[$];
  int unsigned mismatches    = 0;
  int unsigned writes_seen   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ready_hold    = 0;

  segment_lcd_readout_formatter_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .set_temp_i       (set_temp_i),
    .actual_temp_i    (actual_temp_i),
    .set_speed_i      (set_speed_i),
    .actual_speed_i   (actual_speed_i),
    .hide_set_speed_i (hide_set_speed_i),
    .time_preset_i    (time_preset_i),
    .time_value_i     (time_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .lcd_address_o    (lcd_address_o),
    .lcd_data_o       (lcd_data_o),
    .last_write_o     (last_write_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned top);
    return (v > top) ? top : v;
  endfunction

  function automatic logic [7:0] glyph(font_e f, int unsigned d);
    logic [7:0] g;
    case (f)
      FONT_ACT: g = ACT_SEGS[8*d +: 8];
      FONT_SET: g = SET_SEGS[8*d +: 8];
      default:  g = TIM_SEGS[8*d +: 8];
    endcase
    return g;
  endfunction

  function automatic quad_t readout4(int unsigned v, font_e f, bit lead_blank);
    quad_t d;
    d[0] = glyph(f, (v / 1000) % 10);
    d[1] = glyph(f, (v / 100) % 10);
    d[2] = glyph(f, (v / 10) % 10);
    d[3] = glyph(f, v % 10);
    if (lead_blank && v <= 999) d[0] = SEG_OFF;
    if (lead_blank && v <= 99) d[1] = SEG_OFF;
    return d;
  endfunction

  function automatic logic [7:0] seg_hi(logic [7:0] u, logic [7:0] s);
    return ((u >> 4) & 8'h0F) | (s & 8'h70);
  endfunction

  function automatic logic [7:0] seg_lo(logic [7:0] u, logic [7:0] s);
    return (u & 8'h07) | ((s << 3) & 8'h78);
  endfunction

  function automatic frame_t refresh_frame(snapshot_t s);
    int unsigned st, at, sp, ap, t, hi, lo;
    quad_t ts, ta, ss, sa, tm;
    frame_t b;
    st = clamp(s.set_temp, NUM_MAX);
    at = clamp(s.actual_temp, NUM_MAX);
    sp = clamp(s.set_speed, NUM_MAX);
    ap = clamp(s.actual_speed, NUM_MAX);
    t  = clamp(s.tval, TIME_MAX);

    ts = (st == 0) ? {4{SEG_DASH}} : readout4(st, FONT_SET, 1'b1);
    ta = readout4(at, FONT_ACT, 1'b1);
    ss = s.hide ? {4{SEG_OFF}} : readout4(sp, FONT_SET, 1'b0);
    sa = readout4(ap, FONT_ACT, 1'b0);

    if (s.preset == 0) begin
      tm = {4{SEG_DASH}};
    end else begin
      if (s.preset < HOUR_SECS) begin
        hi = (t % HOUR_SECS) / 60;
        lo = t % 60;
      end else begin
        hi = t / HOUR_SECS;
        lo = (t % HOUR_SECS) / 60;
      end
      tm[0] = glyph(FONT_TIM, (hi / 10) % 10);
      tm[1] = glyph(FONT_TIM, hi % 10);
      tm[2] = glyph(FONT_TIM, (lo / 10) % 10);
      tm[3] = glyph(FONT_TIM, lo % 10);
    end

    b[0]  = seg_hi(ta[0], ts[0]);
    b[1]  = seg_lo(ta[0], ts[0]);
    b[2]  = seg_hi(ta[1], ts[1]);
    b[3]  = seg_lo(ta[1], ts[1]);
    b[4]  = seg_hi(ta[2], ts[2]);
    b[5]  = 8'h08 | (ta[2] & 8'h07) | ((ts[2] << 4) & 8'hF0);
    b[6]  = 8'h80 | seg_hi(ta[3], ts[3]);
    b[7]  = 8'h80 | seg_lo(ta[3], ts[3]);
    b[8]  = SEG_OFF;
    b[9]  = seg_hi(sa[0], ss[0]);
    b[10] = seg_lo(sa[0], ss[0]);
    b[11] = seg_hi(sa[1], ss[1]);
    b[12] = ((sa[1] << 1) & 8'h0E) | ((ss[1] << 4) & 8'hF0);
    b[13] = seg_hi(sa[2], ss[2]);
    b[14] = seg_lo(sa[2], ss[2]);
    b[15] = seg_hi(sa[3], ss[3]);
    b[16] = seg_lo(sa[3], ss[3]);
    b[17] = tm[0] & 8'h0F;
    b[18] = (tm[0] >> 4) & 8'h07;
    b[19] = (tm[1] & 8'h0F) | ((LEGEND_P << 1) & 8'hE0);
    b[20] = ((tm[1] >> 3) & 8'h0E) | ((LEGEND_P << 4) & 8'hF0);
    b[21] = (tm[2] & 8'h0F) | ((LEGEND_BAR << 1) & 8'hE0);
    b[22] = ((tm[2] >> 4) & 8'h07) | ((LEGEND_BAR << 4) & 8'hF0);
    b[23] = (tm[3] & 8'h0F) | ((LEGEND_TWO << 1) & 8'hE0);
    b[24] = ((tm[3] >> 4) & 8'h07) | ((LEGEND_TWO << 4) & 8'hF0);
    return b;
  endfunction

  function automatic int unsigned rand_reading();
    case ($urandom_range(9))
      0: return $urandom_range(9);
      1: return $urandom_range(99);
      2: begin
        case ($urandom_range(7))
          0: return 0;
          1: return 99;
          2: return 100;
          3: return 999;
          4: return 1000;
          5: return 9999;
          6: return 10000;
          default: return 16383;
        endcase
      end
      3: return $urandom_range(16383, 10000);
      default: return $urandom_range(9999);
    endcase
  endfunction

  function automatic int unsigned rand_preset();
    case ($urandom_range(9))
      0: return 0;
      1, 2: return $urandom_range(3599, 1);
      3: begin
        case ($urandom_range(5))
          0: return 1;
          1: return 3599;
          2: return 3600;
          3: return 359999;
          4: return 360000;
          default: return 524287;
        endcase
      end
      4: return $urandom_range(524287, 360000);
      default: return $urandom_range(359999, 3600);
    endcase
  endfunction

  function automatic int unsigned rand_seconds();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(7))
          0: return 0;
          1: return 59;
          2: return 60;
          3: return 3599;
          4: return 3600;
          5: return 359999;
          6: return 360000;
          default: return 524287;
        endcase
      end
      1: return $urandom_range(524287, 360000);
      2: return $urandom_range(3599);
      default: return $urandom_range(359999);
    endcase
  endfunction

  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    s.set_temp     = ($urandom_range(15) == 0) ? '0 : NUM_W'(rand_reading());
    s.actual_temp  = NUM_W'(rand_reading());
    s.set_speed    = NUM_W'(rand_reading());
    s.actual_speed = NUM_W'(rand_reading());
    s.hide         = 1'($urandom_range(1));
    s.preset       = TIME_W'(rand_preset());
    s.tval         = TIME_W'(rand_seconds());
    return s;
  endfunction

  task automatic add_row(input int unsigned st, input int unsigned at,
                         input int unsigned sp, input int unsigned ap,
                         input bit hide, input int unsigned pre,
                         input int unsigned tv, input bit golden,
                         input frame_t gold);
    vector_t r;
    r.snap.set_temp     = NUM_W'(st);
    r.snap.actual_temp  = NUM_W'(at);
    r.snap.set_speed    = NUM_W'(sp);
    r.snap.actual_speed = NUM_W'(ap);
    r.snap.hide         = hide;
    r.snap.preset       = TIME_W'(pre);
    r.snap.tval         = TIME_W'(tv);
    r.golden            = golden;
    r.gold              = gold;
    directed_rows.push_back(r);
  endtask

  // holds valid until accepted, then queues the 25 expected writes
  task automatic offer(input snapshot_t s, input bit golden, input frame_t gold);
    int unsigned gap;
    frame_t f;
    lcd_write_t w;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    set_temp_i       <= s.set_temp;
    actual_temp_i    <= s.actual_temp;
    set_speed_i      <= s.set_speed;
    actual_speed_i   <= s.actual_speed;
    hide_set_speed_i <= s.hide;
    time_preset_i    <= s.preset;
    time_value_i     <= s.tval;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    f = golden ? gold : refresh_frame(s);
    for (int k = 0; k < NUM_WRITES; k++) begin
      w.addr = ADDR_W'(2 * k);
      w.data = f[k];
      w.last = (k == NUM_WRITES - 1);
      pending_writes.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= ready_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_writes
    lcd_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("write %0d to address %0d with nothing expected",
                                  writes_seen, lcd_address_o));
      end else begin
        want = pending_writes.pop_front();
        if (lcd_address_o !== want.addr)
          report_mismatch($sformatf("write %0d: address %0d, expected %0d",
                                    writes_seen, lcd_address_o, want.addr));
        if (lcd_data_o !== want.data)
          report_mismatch($sformatf("write %0d at %0d: data %h, expected %h",
                                    writes_seen, want.addr, lcd_data_o, want.data));
        if (last_write_o !== want.last)
          report_mismatch($sformatf("write %0d at %0d: last %b, expected %b",
                                    writes_seen, want.addr, last_write_o, want.last));
      end
      writes_seen++;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_ready_i      = 1'b0;
    set_temp_i       = '0;
    actual_temp_i    = '0;
    set_speed_i      = '0;
    actual_speed_i   = '0;
    hide_set_speed_i = 1'b0;
    time_preset_i    = '0;
    time_value_i     = '0;

    // all zero, all ones, digit blanking edges, time mode edges, saturation
    add_row(0, 0, 0, 0, 0, 0, 0, 1, GOLD_ZERO);
    add_row(16383, 16383, 16383, 16383, 0, 524287, 524287, 1, GOLD_MAX);
    add_row(5, 5, 5, 5, 0, 1, 0, 0, NO_GOLD);
    add_row(99, 99, 99, 99, 0, 3599, 3599, 0, NO_GOLD);
    add_row(100, 100, 100, 100, 1, 3600, 3600, 0, NO_GOLD);
    add_row(999, 999, 999, 999, 0, 3600, 359999, 0, NO_GOLD);
    add_row(1000, 1000, 1000, 1000, 0, 60, 360000, 0, NO_GOLD);
    add_row(9999, 9999, 9999, 9999, 0, 359999, 359999, 0, NO_GOLD);
    add_row(10000, 10000, 10000, 10000, 1, 360000, 0, 0, NO_GOLD);
    add_row(0, 1234, 5678, 9012, 0, 90, 125, 0, NO_GOLD);
    add_row(1, 0, 0, 9999, 1, 0, 12345, 0, NO_GOLD);
    add_row(9, 10, 1, 1, 0, 7200, 7199, 0, NO_GOLD);
    add_row(12, 345, 6789, 4321, 0, 1, 524287, 0, NO_GOLD);
    add_row(16383, 0, 16383, 0, 1, 524287, 0, 0, NO_GOLD);
    add_row(2468, 1357, 8642, 7531, 0, 3000, 3000, 0, NO_GOLD);
    add_row(10, 9, 9999, 0, 0, 262144, 262144, 0, NO_GOLD);
    add_row(8191, 4096, 4095, 2048, 0, 1, 59, 0, NO_GOLD);
    add_row(0, 0, 16383, 16383, 1, 3599, 60, 0, NO_GOLD);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer(directed_rows[i].snap, directed_rows[i].golden, directed_rows[i].gold);

    repeat (110) offer(random_snapshot(), 1'b0, NO_GOLD);

    send_idle_pct = 48;
    repeat (105) offer(random_snapshot(), 1'b0, NO_GOLD);

    // output held off while items keep coming, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ready_hold <= 400;
    repeat (20) offer(random_snapshot(), 1'b0, NO_GOLD);

    recv_stall_pct = 48;
    repeat (105) offer(random_snapshot(), 1'b0, NO_GOLD);

    send_idle_pct = 38;
    recv_stall_pct = 38;
    repeat (105) offer(random_snapshot(), 1'b0, NO_GOLD);

    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
